// ===== hw/rtl/rbsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsd_pkg
// Shared types and constants of the run-length byte stream decoder.
// ----------------------------------------------------------------------------
package rbsd_pkg;

  localparam int BYTE_BITS = 8;
  localparam int SIZE_BITS = 24;
  localparam int LITERAL_FLAG_BIT = 7;

  localparam logic [BYTE_BITS-1:0] REPEAT_BIAS = 8'd3;
  localparam logic [SIZE_BITS-1:0] SIZE_RESET = 24'd65536;

  // Decoder phase. Code 3 is unused and is handled as a header.
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LITERAL = 2'd1,
    PH_REPEAT  = 2'd2
  } phase_t;

  // One decoded run as handed to the output buffer.
  typedef struct packed {
    logic [BYTE_BITS-1:0] value;
    logic [BYTE_BITS-1:0] run_length;
    logic                 last;
  } result_t;

endpackage

// ===== hw/rtl/rbsd_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsd_decode
// Decoder state and the single-pass decode of one compressed byte.
// ----------------------------------------------------------------------------
module rbsd_decode #(
  parameter int COUNT_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [rbsd_pkg::SIZE_BITS-1:0]     output_size,
  input  logic                               fire,
  input  logic [rbsd_pkg::BYTE_BITS-1:0]     code_byte,
  output logic                               res_valid,
  output rbsd_pkg::result_t                  res
);

  localparam int CMP_BITS = (COUNT_BITS > rbsd_pkg::SIZE_BITS) ? COUNT_BITS
                                                                 : rbsd_pkg::SIZE_BITS;

  rbsd_pkg::phase_t                    phase, phase_next;
  logic [rbsd_pkg::BYTE_BITS-1:0]      run_left, run_left_next;
  logic [rbsd_pkg::BYTE_BITS-1:0]      repeat_count, repeat_count_next;
  logic [COUNT_BITS-1:0]               bytes_written, bytes_written_next;

  logic                                emit;
  logic [rbsd_pkg::BYTE_BITS-1:0]      len;
  logic [CMP_BITS-1:0]                 size_w, written_w, rem;
  logic                                fin;
  logic [rbsd_pkg::BYTE_BITS-1:0]      run_dec;

  // Bytes still missing from the stream; at least one.
  assign size_w    = CMP_BITS'(output_size);
  assign written_w = CMP_BITS'(bytes_written);
  assign rem       = (size_w > written_w) ? (size_w - written_w) : CMP_BITS'(1);
  assign fin       = (CMP_BITS'(len) >= rem);
  assign run_dec   = (run_left != '0) ? (run_left - 8'd1) : '0;

  always_comb begin
    phase_next        = phase;
    run_left_next     = run_left;
    repeat_count_next = repeat_count;
    emit              = 1'b0;
    len               = 8'd1;
    unique case (phase)
      rbsd_pkg::PH_LITERAL: begin
        emit          = 1'b1;
        run_left_next = run_dec;
        if (run_dec == '0) begin
          phase_next = rbsd_pkg::PH_HEADER;
        end
      end
      rbsd_pkg::PH_REPEAT: begin
        emit       = 1'b1;
        len        = repeat_count;
        phase_next = rbsd_pkg::PH_HEADER;
      end
      default: begin
        if (code_byte[rbsd_pkg::LITERAL_FLAG_BIT]) begin
          run_left_next = {1'b0, code_byte[rbsd_pkg::LITERAL_FLAG_BIT-1:0]} + 8'd1;
          phase_next    = rbsd_pkg::PH_LITERAL;
        end else begin
          repeat_count_next = code_byte + rbsd_pkg::REPEAT_BIAS;
          phase_next        = rbsd_pkg::PH_REPEAT;
        end
      end
    endcase

    bytes_written_next = bytes_written;
    if (emit) begin
      if (fin) begin
        bytes_written_next = '0;
        phase_next         = rbsd_pkg::PH_HEADER;
        run_left_next      = '0;
      end else begin
        bytes_written_next = bytes_written + COUNT_BITS'(len);
      end
    end

    res_valid      = fire && emit;
    res.value      = code_byte;
    res.run_length = fin ? rem[rbsd_pkg::BYTE_BITS-1:0] : len;
    res.last       = fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= rbsd_pkg::PH_HEADER;
      run_left      <= '0;
      repeat_count  <= '0;
      bytes_written <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      run_left      <= run_left_next;
      repeat_count  <= repeat_count_next;
      bytes_written <= bytes_written_next;
    end
  end

endmodule

// ===== hw/rtl/rbsd_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsd_out_buf
// Result register with skid entry; decode stalls only once the skid is full.
// ----------------------------------------------------------------------------
module rbsd_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rbsd_pkg::result_t push_data,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output rbsd_pkg::result_t out_data
);

  logic              skid_valid;
  rbsd_pkg::result_t skid_data;
  logic              pop;

  assign space = !skid_valid;
  assign pop   = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      if (!out_valid) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule

// ===== hw/rtl/rle_byte_stream_decoder.sv =====
`timescale 1ns / 1ps
// Path: a data byte's result is held in the input register, then in the
// result register, before it is valid on the output; a full skid entry
// stalls it in the input register.
// Throughput: one compressed byte per cycle while the skid entry is free; the
// single-pass decode from input register to two-entry result buffer sets it.
// Reset: synchronous, active high; clears the stream count, the decoder phase
// and all valid flags, and sets output_size to 65536.
// ----------------------------------------------------------------------------
// rle_byte_stream_decoder
// Run-length decoder for a byte stream of literal runs and repeat runs.
// ----------------------------------------------------------------------------
//
// A header byte with bit 7 set opens a literal run of (low 7 bits + 1) bytes;
// each literal byte leaves as one item with run length 1. Any other header h
// makes the next byte a repeat of h + 3. Run lengths are clipped to the bytes
// still missing from output_size, and the item that reaches it carries tlast,
// after which the byte count clears and a new header is expected. Header
// bytes produce no item.
module rle_byte_stream_decoder #(
  parameter int COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,

  // Configuration: output_size, written whenever cfg_we is high.
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,

  // Compressed input. tdata: code_byte [7:0].
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,

  // Decoded runs. tdata: value [7:0], run_length [15:8]. tlast: last.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  logic [rbsd_pkg::SIZE_BITS-1:0] output_size;

  // Input register. It moves on whenever the result buffer's skid entry is
  // free; a header byte would not need the room, but the simpler rule costs
  // nothing at steady state since the skid entry only fills under stall.
  logic                           in_valid;
  logic [rbsd_pkg::BYTE_BITS-1:0] in_byte;
  logic                           fire;
  logic                           space;

  logic                           res_valid;
  rbsd_pkg::result_t              res;
  rbsd_pkg::result_t              out_data;

  assign fire          = in_valid && space;
  assign s_axis_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_size <= rbsd_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      output_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  // Decoder state and the per-byte decode.
  rbsd_decode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_decode (
    .clk         (clk),
    .rst         (rst),
    .output_size (output_size),
    .fire        (fire),
    .code_byte   (in_byte),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Result register plus skid entry toward the consumer.
  rbsd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data)
  );

  assign m_axis_tdata = {out_data.run_length, out_data.value};
  assign m_axis_tlast = out_data.last;

endmodule
